[rtl/pdtq_pkg.sv]
// ----------------------------------------------------------------------------
// Periodic deadline task queue package
// Shared widths, function codes, sequencer states and arithmetic unit types.
// ----------------------------------------------------------------------------
`default_nettype none

package pdtq_pkg;

  localparam int ID_W       = 4;
  localparam int FUNC_W     = 2;
  localparam int PERIOD_W   = 31;
  localparam int TIME_W     = 47;
  localparam int DL_W       = 48;
  localparam int WAIT_W     = 32;
  localparam int NUM_IDS    = 2 ** ID_W;
  localparam int TASKS_DEF  = 16;
  localparam int IN_DATA_W  = 88;
  localparam int OUT_DATA_W = 88;

  localparam logic [WAIT_W-1:0] WAIT_MAX   = {1'b0, {(WAIT_W-1){1'b1}}};
  localparam logic [WAIT_W-1:0] WAIT_EMPTY = {WAIT_W{1'b1}};

  typedef enum logic [FUNC_W-1:0] {
    FUNC_ADD    = 2'd0,
    FUNC_REMOVE = 2'd1,
    FUNC_POLL   = 2'd2,
    FUNC_QUERY  = 2'd3
  } func_t;

  typedef enum logic {
    KIND_DISPATCH = 1'b0,
    KIND_SUMMARY  = 1'b1
  } kind_t;

  typedef enum logic {
    STATUS_OK      = 1'b0,
    STATUS_MISSING = 1'b1
  } status_t;

  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_t;

  typedef struct packed {
    logic [DL_W:0] res;
    logic          neg;
    logic          zero;
  } alu_res_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_UL_SCAN,
    S_UL_SHIFT,
    S_WHEN,
    S_INS_SCAN,
    S_INS_SHIFT,
    S_POLL_SCAN,
    S_FIRE,
    S_SUM
  } state_t;

endpackage

`default_nettype wire

[rtl/periodic_deadline_task_queue.sv]
// ----------------------------------------------------------------------------
// Periodic deadline task queue
// Deadline-sorted queue of periodic tasks driven by a shared-adder sequencer.
// ----------------------------------------------------------------------------
// Each input request carries a function (add, remove, poll, query), a task id,
// a period and the current time in ms. Add schedules the task at now plus its
// period ahead of equal deadlines; remove unlinks it; poll dispatches every
// task due on arrival in deadline order and reschedules it. Every request ends
// with a summary result (out_tlast high) giving the ms to the earliest deadline.
// Requests are handled one at a time; in_tready is high only while idle.
// All deadline arithmetic goes through one 49-bit adder, one step per cycle
// while the output is not stalled. Steps from one accept to the next:
//   query, remove of an absent task, or add of an out-of-range id: summary
//   remove: unlink scan to the task's position, unlink shift, summary
//   add: unlink scan and shift if the task was queued, then deadline sum,
//   insertion scan, insertion shift and summary
//   poll: a scan counting the due tasks, then per dispatched task an unlink
//   scan and shift, deadline sum, insertion scan and shift and a dispatch,
//   then the summary.
// Results sit in an output register; when the receiver stalls the sequencer
// waits in its dispatch or summary step and the queue state is held.
// Reset empties the queue at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module periodic_deadline_task_queue #(
  parameter int TASKS = pdtq_pkg::TASKS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // task_id [3:0], period [34:4], now [81:35], zero fill above
  input  logic [pdtq_pkg::IN_DATA_W-1:0]      in_tdata,
  // func [1:0]
  input  logic [pdtq_pkg::FUNC_W-1:0]         in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // fired_task [3:0], fire_time [50:4], wait_ms [82:51], status [83], zero fill
  output logic [pdtq_pkg::OUT_DATA_W-1:0]     out_tdata,
  // kind [0]
  output logic [0:0]                          out_tuser,
  output logic                                out_tlast
);
  import pdtq_pkg::*;

  localparam int SLOTS = (TASKS < NUM_IDS) ? TASKS : NUM_IDS;
  localparam int PW    = $clog2(SLOTS);
  localparam int CW    = $clog2(SLOTS + 1);
  localparam logic [ID_W:0] SLOTS_L = (ID_W + 1)'(SLOTS);

  state_t                 state_r, state_nxt;

  func_t                  func_r;
  logic [ID_W-1:0]        cur_id_r;
  logic [TIME_W-1:0]      now_r;
  status_t                status_r;
  logic [DL_W-1:0]        when_r;
  logic [CW-1:0]          pos_r;
  logic [CW-1:0]          due_k_r;
  logic [PW-1:0]          fire_i_r;
  logic [CW-1:0]          count_r;
  logic [SLOTS-1:0]       active_r;

  logic [ID_W-1:0]        qid_r [SLOTS];
  logic [DL_W-1:0]        qdl_r [SLOTS];
  logic [PERIOD_W-1:0]    rep_r [SLOTS];
  logic [ID_W-1:0]        due_r [SLOTS];

  logic                   out_valid_r;
  kind_t                  out_kind_r;
  logic [ID_W-1:0]        out_task_r;
  logic [TIME_W-1:0]      out_time_r;
  logic [WAIT_W-1:0]      out_wait_r;
  status_t                out_status_r;
  logic                   out_last_r;

  // Request fields
  func_t                  in_func;
  logic [ID_W-1:0]        in_id;
  logic [PERIOD_W-1:0]    in_period;
  logic [TIME_W-1:0]      in_now;
  logic                   in_fire;
  logic                   in_id_ok;
  logic                   in_active;
  logic [PW-1:0]          in_slot;

  // Sequencer datapath
  logic [PW-1:0]          cur_slot;
  logic [PW-1:0]          rd_pos;
  logic [DL_W-1:0]        rd_dl;
  logic [ID_W-1:0]        rd_id;
  alu_op_t                alu_op;
  logic [DL_W-1:0]        alu_a;
  logic [DL_W-1:0]        alu_b;
  alu_res_t               alu_r;
  logic                   scan_more;
  logic                   ins_go;
  logic                   poll_go;
  logic                   ul_hit;
  logic                   fire_last;
  logic                   out_free;
  logic                   emit_dispatch;
  logic                   emit_sum;
  logic [WAIT_W-1:0]      wait_sum;

  assign in_func   = func_t'(in_tuser);
  assign in_id     = in_tdata[ID_W-1:0];
  assign in_period = in_tdata[ID_W +: PERIOD_W];
  assign in_now    = in_tdata[ID_W+PERIOD_W +: TIME_W];
  assign in_slot   = in_id[PW-1:0];
  assign in_id_ok  = ({1'b0, in_id} < SLOTS_L);
  assign in_active = in_id_ok && active_r[in_slot];

  assign cur_slot  = cur_id_r[PW-1:0];

  pdtq_alu u_alu (
    .op (alu_op),
    .a  (alu_a),
    .b  (alu_b),
    .r  (alu_r)
  );

  // Control and operand selection
  always_comb begin
    in_tready = (state_r == S_IDLE);
    in_fire   = in_tvalid && in_tready;
    out_free  = !out_valid_r || out_tready;

    rd_pos = (state_r == S_SUM) ? '0 : pos_r[PW-1:0];
    rd_dl  = qdl_r[rd_pos];
    rd_id  = qid_r[rd_pos];

    case (state_r)
      S_WHEN: begin
        alu_op = ALU_ADD;
        alu_a  = {1'b0, now_r};
        alu_b  = {{(DL_W-PERIOD_W){1'b0}}, rep_r[cur_slot]};
      end
      S_INS_SCAN: begin
        alu_op = ALU_SUB;
        alu_a  = rd_dl;
        alu_b  = when_r;
      end
      default: begin
        alu_op = ALU_SUB;
        alu_a  = rd_dl;
        alu_b  = {1'b0, now_r};
      end
    endcase

    scan_more = (pos_r < count_r);
    ins_go    = scan_more && alu_r.neg;
    poll_go   = scan_more && (alu_r.neg || alu_r.zero);
    ul_hit    = (rd_id == cur_id_r);
    fire_last = ((CW'(fire_i_r) + CW'(1)) == due_k_r);

    emit_dispatch = (state_r == S_FIRE) && out_free;
    emit_sum      = (state_r == S_SUM) && out_free;

    // Head deadline minus now, clamped at zero and saturated at the top; WAIT_EMPTY when empty.
    if (count_r == '0) begin
      wait_sum = WAIT_EMPTY;
    end else if (alu_r.neg || alu_r.zero) begin
      wait_sum = '0;
    end else if (|alu_r.res[DL_W-1:WAIT_W-1]) begin
      wait_sum = WAIT_MAX;
    end else begin
      wait_sum = {1'b0, alu_r.res[WAIT_W-2:0]};
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          case (in_func)
            FUNC_ADD: begin
              if (!in_id_ok) begin
                state_nxt = S_SUM;
              end else if (in_active) begin
                state_nxt = S_UL_SCAN;
              end else begin
                state_nxt = S_WHEN;
              end
            end
            FUNC_REMOVE: state_nxt = in_active ? S_UL_SCAN : S_SUM;
            FUNC_POLL:   state_nxt = S_POLL_SCAN;
            default:     state_nxt = S_SUM;
          endcase
        end
      end
      S_UL_SCAN: begin
        if (ul_hit) begin
          state_nxt = S_UL_SHIFT;
        end
      end
      S_UL_SHIFT:  state_nxt = (func_r == FUNC_REMOVE) ? S_SUM : S_WHEN;
      S_WHEN:      state_nxt = S_INS_SCAN;
      S_INS_SCAN: begin
        if (!ins_go) begin
          state_nxt = S_INS_SHIFT;
        end
      end
      S_INS_SHIFT: state_nxt = (func_r == FUNC_POLL) ? S_FIRE : S_SUM;
      S_POLL_SCAN: begin
        if (!poll_go) begin
          state_nxt = (pos_r == '0) ? S_SUM : S_UL_SCAN;
        end
      end
      S_FIRE: begin
        if (out_free) begin
          state_nxt = fire_last ? S_SUM : S_UL_SCAN;
        end
      end
      S_SUM: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Queue occupancy and output handshake
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (emit_dispatch || emit_sum) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (state_r == S_UL_SHIFT) begin
        active_r[cur_slot] <= 1'b0;
        count_r            <= count_r - CW'(1);
      end else if (state_r == S_INS_SHIFT) begin
        active_r[cur_slot] <= 1'b1;
        count_r            <= count_r + CW'(1);
      end
    end
  end

  // Request registers, queue contents and scan counters
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          func_r   <= in_func;
          cur_id_r <= in_id;
          now_r    <= in_now;
          status_r <= (in_func == FUNC_REMOVE && !in_active) ? STATUS_MISSING : STATUS_OK;
          pos_r    <= '0;
          if (in_func == FUNC_ADD && in_id_ok) begin
            rep_r[in_slot] <= in_period;
          end
          // Poll fires the tasks that lead the queue on arrival.
          for (int j = 0; j < SLOTS; j++) begin
            due_r[j] <= qid_r[j];
          end
        end
      end
      S_UL_SCAN: begin
        if (!ul_hit) begin
          pos_r <= pos_r + CW'(1);
        end
      end
      S_UL_SHIFT: begin
        for (int j = 0; j < SLOTS - 1; j++) begin
          if (CW'(j) >= pos_r) begin
            qid_r[j] <= qid_r[j+1];
            qdl_r[j] <= qdl_r[j+1];
          end
        end
        pos_r <= '0;
      end
      S_WHEN: begin
        when_r <= alu_r.res[DL_W-1:0];
        pos_r  <= '0;
      end
      S_INS_SCAN: begin
        if (ins_go) begin
          pos_r <= pos_r + CW'(1);
        end
      end
      S_INS_SHIFT: begin
        for (int j = 1; j < SLOTS; j++) begin
          if (CW'(j) > pos_r) begin
            qid_r[j] <= qid_r[j-1];
            qdl_r[j] <= qdl_r[j-1];
          end
        end
        qid_r[pos_r[PW-1:0]] <= cur_id_r;
        qdl_r[pos_r[PW-1:0]] <= when_r;
        pos_r                <= '0;
      end
      S_POLL_SCAN: begin
        if (poll_go) begin
          pos_r <= pos_r + CW'(1);
        end else begin
          due_k_r  <= pos_r;
          fire_i_r <= '0;
          cur_id_r <= due_r[0];
          pos_r    <= '0;
        end
      end
      S_FIRE: begin
        if (out_free && !fire_last) begin
          fire_i_r <= fire_i_r + PW'(1);
          cur_id_r <= due_r[fire_i_r + PW'(1)];
        end
      end
      default: begin
      end
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (emit_dispatch) begin
      out_kind_r   <= KIND_DISPATCH;
      out_task_r   <= cur_id_r;
      out_time_r   <= now_r;
      out_wait_r   <= '0;
      out_status_r <= STATUS_OK;
      out_last_r   <= 1'b0;
    end else if (emit_sum) begin
      out_kind_r   <= KIND_SUMMARY;
      out_task_r   <= '0;
      out_time_r   <= '0;
      out_wait_r   <= wait_sum;
      out_status_r <= status_r;
      out_last_r   <= 1'b1;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W-ID_W-TIME_W-WAIT_W-1){1'b0}},
                       out_status_r, out_wait_r, out_time_r, out_task_r};
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

endmodule

`default_nettype wire

[rtl/pdtq_alu.sv]
// ----------------------------------------------------------------------------
// Shared add / subtract unit
// One 49-bit adder used for deadline sums, ordering compares and wait times.
// ----------------------------------------------------------------------------
`default_nettype none

module pdtq_alu (
  input  pdtq_pkg::alu_op_t               op,
  input  logic [pdtq_pkg::DL_W-1:0]       a,
  input  logic [pdtq_pkg::DL_W-1:0]       b,
  output pdtq_pkg::alu_res_t              r
);
  import pdtq_pkg::*;

  logic [DL_W:0] sum;

  always_comb begin
    if (op == ALU_ADD) begin
      sum = {1'b0, a} + {1'b0, b};
    end else begin
      sum = {1'b0, a} - {1'b0, b};
    end
    r.res  = sum;
    // For a subtract the top bit is the borrow, so it flags a below b.
    r.neg  = sum[DL_W];
    r.zero = (sum == '0);
  end

endmodule

`default_nettype wire
